/* rtl/bc1_block_encoder_unit_defines.svh */
// Assertion macros used by the BC1 block encoder checker.
`ifndef BC1_BLOCK_ENCODER_UNIT_DEFINES_SVH
`define BC1_BLOCK_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define BC1_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bc1 encoder check failed");

// Next-cycle implication, off during reset.
`define BC1_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bc1 encoder check failed");

`endif

/* rtl/bc1_pkg.sv */
// Types, constants and helper functions of the BC1 block encoder.
package bc1_pkg;

   localparam int unsigned BlockPixels = 16;

   typedef logic [7:0]  chan_type;
   typedef logic [23:0] pixel_type;
   typedef logic [15:0] color_type;
   typedef logic [17:0] dist_type;
   typedef logic [6:0]  step_type;
   typedef logic [3:0]  addr_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN1,
      ST_SCAN2,
      ST_PACK,
      ST_PAL,
      ST_INDEX,
      ST_OUT
   } state_type;

   localparam addr_type  LastPixel  = addr_type'(BlockPixels - 1);
   localparam step_type  ScanIssue  = step_type'(BlockPixels);
   localparam step_type  ScanLast   = step_type'(BlockPixels + 1);
   localparam step_type  IndexIssue = step_type'(BlockPixels * 4);
   localparam step_type  IndexLast  = step_type'(BlockPixels * 4 + 1);
   localparam step_type  PalLast    = step_type'(2);
   localparam color_type Max565     = 16'hFFFF;
   localparam logic [1:0] LastEntry = 2'd3;
   localparam logic [20:0] Recip3   = 21'd683;
   localparam logic [16:0] Recip31  = 17'd265;
   localparam logic [15:0] Recip63  = 16'd261;

   typedef struct packed {
      logic       wr_en;
      addr_type   wr_addr;
      logic       rd_en;
      addr_type   rd_addr;
      logic [1:0] pal_sel;
      logic       index_mode;
      logic       ref_load;
      logic       pack_en;
      logic       pal_en;
      logic [1:0] pal_chan;
   } ctrl_type;

   function automatic color_type pack565(pixel_type p);
      return {p[23:19], p[15:10], p[7:3]};
   endfunction

   // round v * 255 / 31: 8 * v plus (7 * v + 15) / 31
   function automatic chan_type expand5(logic [4:0] v);
      logic [7:0]  y;
      logic [16:0] prod;
      y    = 8'(v) * 8'd7 + 8'd15;
      prod = 17'(y) * Recip31;
      return {v, 3'b000} + 8'(prod[15:13]);
   endfunction

   // round g * 255 / 63: 4 * g plus (3 * g + 31) / 63
   function automatic chan_type expand6(logic [5:0] g);
      logic [7:0]  y;
      logic [15:0] prod;
      y    = 8'(g) * 8'd3 + 8'd31;
      prod = 16'(y) * Recip63;
      return {g, 2'b00} + 8'(prod[15:14]);
   endfunction

   function automatic pixel_type expand565(color_type v);
      return {expand5(v[15:11]), expand6(v[10:5]), expand5(v[4:0])};
   endfunction

   function automatic chan_type div3(logic [9:0] n);
      logic [20:0] prod;
      prod = 21'(n) * Recip3;
      return prod[18:11];
   endfunction

endpackage

/* rtl/bc1_if.sv */
// Request and response channel interfaces of the BC1 block encoder.
interface bc1_req_if;
   logic                valid;
   logic                ready;
   bc1_pkg::chan_type   red;
   bc1_pkg::chan_type   green;
   bc1_pkg::chan_type   blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface bc1_rsp_if;
   logic                valid;
   logic                ready;
   bc1_pkg::color_type  color_high;
   bc1_pkg::color_type  color_low;
   logic [31:0]         index_bits;

   modport source (output valid, output color_high, output color_low, output index_bits,
                   input ready);
   modport sink   (input valid, input color_high, input color_low, input index_bits,
                   output ready);
endinterface

/* rtl/bc1_dist_unit.sv */
// Shared squared RGB distance unit with registered result.
module bc1_dist_unit (
   input  logic                clock,
   input  bc1_pkg::pixel_type  a_pix,
   input  bc1_pkg::pixel_type  b_pix,
   output bc1_pkg::dist_type   dist_ff
);

   logic signed [8:0]  diff [3];
   logic signed [17:0] prod [3];
   logic [15:0]        sq [3];
   bc1_pkg::dist_type  dist_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c] = $signed({1'b0, a_pix[c*8 +: 8]}) - $signed({1'b0, b_pix[c*8 +: 8]});
         prod[c] = diff[c] * diff[c];
         sq[c]   = prod[c][15:0];
      end
      dist_in = 18'(sq[0]) + 18'(sq[1]) + 18'(sq[2]);
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

endmodule

/* rtl/bc1_seq.sv */
// Sequencer of the BC1 block encoder: pixel count, phases and step counter.
module bc1_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bc1_pkg::ctrl_type  ctrl
);

   bc1_pkg::state_type state_ff, state_in;
   bc1_pkg::step_type  step_ff, step_in;
   bc1_pkg::addr_type  count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bc1_pkg::ST_LOAD;
         step_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff + 7'd1;
      count_in = count_ff;
      case (state_ff)
         bc1_pkg::ST_LOAD: begin
            step_in = '0;
            if (req_valid) begin
               count_in = count_ff + 4'd1;
               if (count_ff == bc1_pkg::LastPixel) begin
                  state_in = bc1_pkg::ST_SCAN1;
               end
            end
         end
         bc1_pkg::ST_SCAN1: begin
            if (step_ff == bc1_pkg::ScanLast) begin
               state_in = bc1_pkg::ST_SCAN2;
               step_in  = '0;
            end
         end
         bc1_pkg::ST_SCAN2: begin
            if (step_ff == bc1_pkg::ScanLast) begin
               state_in = bc1_pkg::ST_PACK;
               step_in  = '0;
            end
         end
         bc1_pkg::ST_PACK: begin
            state_in = bc1_pkg::ST_PAL;
            step_in  = '0;
         end
         bc1_pkg::ST_PAL: begin
            if (step_ff == bc1_pkg::PalLast) begin
               state_in = bc1_pkg::ST_INDEX;
               step_in  = '0;
            end
         end
         bc1_pkg::ST_INDEX: begin
            if (step_ff == bc1_pkg::IndexLast) begin
               state_in = bc1_pkg::ST_OUT;
               step_in  = '0;
            end
         end
         bc1_pkg::ST_OUT: begin
            step_in = '0;
            if (rsp_ready) begin
               state_in = bc1_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = bc1_pkg::ST_LOAD;
            step_in  = '0;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctrl      = '0;
      case (state_ff)
         bc1_pkg::ST_LOAD: begin
            req_ready    = 1'b1;
            ctrl.wr_en   = req_valid;
            ctrl.wr_addr = count_ff;
         end
         bc1_pkg::ST_SCAN1: begin
            ctrl.rd_en   = (step_ff < bc1_pkg::ScanIssue);
            ctrl.rd_addr = step_ff[3:0];
         end
         bc1_pkg::ST_SCAN2: begin
            ctrl.rd_en    = (step_ff < bc1_pkg::ScanIssue);
            ctrl.rd_addr  = step_ff[3:0];
            ctrl.ref_load = (step_ff == '0);
         end
         bc1_pkg::ST_PACK: begin
            ctrl.pack_en = 1'b1;
         end
         bc1_pkg::ST_PAL: begin
            ctrl.pal_en   = 1'b1;
            ctrl.pal_chan = step_ff[1:0];
         end
         bc1_pkg::ST_INDEX: begin
            ctrl.rd_en      = (step_ff < bc1_pkg::IndexIssue);
            ctrl.rd_addr    = step_ff[5:2];
            ctrl.pal_sel    = step_ff[1:0];
            ctrl.index_mode = 1'b1;
         end
         bc1_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

/* rtl/bc1_datapath.sv */
// Pixel store, farthest-pixel search, endpoint packing, palette and index pass.
module bc1_datapath (
   input  logic                clock,
   input  logic                reset,
   input  bc1_pkg::ctrl_type   ctrl,
   input  bc1_pkg::pixel_type  wr_pix,
   output bc1_pkg::color_type  color_high,
   output bc1_pkg::color_type  color_low,
   output logic [31:0]         index_bits
);

   bc1_pkg::pixel_type store_mem [bc1_pkg::BlockPixels];

   bc1_pkg::pixel_type mem_q_ff;
   logic               v1_ff, v2_ff;
   logic               first1_ff, first2_ff;
   logic [1:0]         k1_ff, k2_ff;
   logic               mode1_ff, mode2_ff;
   bc1_pkg::pixel_type pix2_ff;

   bc1_pkg::pixel_type ref_ff;
   bc1_pkg::pixel_type best_pix_ff;
   bc1_pkg::dist_type  best_dist_ff;
   bc1_pkg::dist_type  score_ff;
   logic [1:0]         best_k_ff, best_k_in;
   logic [31:0]        index_ff;
   bc1_pkg::color_type high_ff, low_ff;
   logic [3:0][2:0][7:0] pal_ff;

   logic               first0;
   bc1_pkg::pixel_type dist_b;
   bc1_pkg::dist_type  cur_dist;
   logic               scan_take, index_take;
   bc1_pkg::color_type pa, pb, na, nb, hi, lo;
   bc1_pkg::chan_type  e0, e1;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         store_mem[ctrl.wr_addr] <= wr_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         mem_q_ff <= store_mem[ctrl.rd_addr];
      end
   end

   assign first0 = ctrl.index_mode ? (ctrl.pal_sel == 2'd0) : (ctrl.rd_addr == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.rd_en;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= first0;
      k1_ff     <= ctrl.pal_sel;
      mode1_ff  <= ctrl.index_mode;
      first2_ff <= first1_ff;
      k2_ff     <= k1_ff;
      mode2_ff  <= mode1_ff;
      pix2_ff   <= mem_q_ff;
   end

   assign dist_b = mode1_ff ? pal_ff[k1_ff] : ref_ff;

   bc1_dist_unit u_dist (
      .clock   (clock),
      .a_pix   (mem_q_ff),
      .b_pix   (dist_b),
      .dist_ff (cur_dist)
   );

   assign scan_take  = first2_ff || (cur_dist > best_dist_ff);
   assign index_take = first2_ff || (cur_dist < score_ff);
   assign best_k_in  = index_take ? k2_ff : best_k_ff;

   always_ff @(posedge clock) begin
      if (v2_ff && !mode2_ff && scan_take) begin
         best_dist_ff <= cur_dist;
         best_pix_ff  <= pix2_ff;
      end
      if (v2_ff && mode2_ff) begin
         best_k_ff <= best_k_in;
         if (index_take) begin
            score_ff <= cur_dist;
         end
         if (k2_ff == bc1_pkg::LastEntry) begin
            index_ff <= {best_k_in, index_ff[31:2]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en && (ctrl.wr_addr == '0)) begin
         ref_ff <= wr_pix;
      end else if (ctrl.ref_load) begin
         ref_ff <= best_pix_ff;
      end
   end

   always_comb begin
      pa = bc1_pkg::pack565(ref_ff);
      pb = bc1_pkg::pack565(best_pix_ff);
      na = pa;
      nb = pb;
      if (pa == pb) begin
         if (pa != bc1_pkg::Max565) begin
            na = pa + 16'd1;
         end else begin
            nb = pb - 16'd1;
         end
      end
      hi = (na < nb) ? nb : na;
      lo = (na < nb) ? na : nb;
   end

   assign e0 = pal_ff[0][ctrl.pal_chan];
   assign e1 = pal_ff[1][ctrl.pal_chan];

   always_ff @(posedge clock) begin
      if (ctrl.pack_en) begin
         high_ff   <= hi;
         low_ff    <= lo;
         pal_ff[0] <= bc1_pkg::expand565(hi);
         pal_ff[1] <= bc1_pkg::expand565(lo);
      end
      if (ctrl.pal_en) begin
         pal_ff[2][ctrl.pal_chan] <= bc1_pkg::div3(10'({e0, 1'b0}) + 10'(e1));
         pal_ff[3][ctrl.pal_chan] <= bc1_pkg::div3(10'(e0) + 10'({e1, 1'b0}));
      end
   end

   assign color_high = high_ff;
   assign color_low  = low_ff;
   assign index_bits = index_ff;

endmodule

/* rtl/bc1_block_encoder_unit.sv */
// Top level of the BC1 block encoder.
// Usage:
//   req_ch carries one RGB888 pixel per request; sixteen requests form one
//   4x4 block in row order. req_ch.ready is high while pixels are gathered,
//   so pixels of a block are taken one per cycle.
//   After the sixteenth pixel the block goes busy and ready drops. It runs
//   two farthest-pixel scans, endpoint packing, palette build and the index
//   pass; the scans and the index pass share one squared-distance unit fed
//   from the pixel store's single read port. rsp_ch.valid rises after the
//   index pass and carries color_high, color_low and index_bits from
//   output registers.
//   If the receiver stalls, the response holds and no new pixel is taken
//   until it is accepted; ready returns the cycle after.
//   Synchronous reset empties the block: the pixel count goes to zero and
//   any response in progress is dropped.
module bc1_block_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   bc1_req_if.sink    req_ch,
   bc1_rsp_if.source  rsp_ch
);

   bc1_pkg::ctrl_type ctrl;

   bc1_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   bc1_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .wr_pix     ({req_ch.red, req_ch.green, req_ch.blue}),
      .color_high (rsp_ch.color_high),
      .color_low  (rsp_ch.color_low),
      .index_bits (rsp_ch.index_bits)
   );

endmodule

/* rtl/bc1_checker.sv */
// Port-level checker of the BC1 block encoder and its bind.
`include "bc1_block_encoder_unit_defines.svh"

module bc1_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input bc1_pkg::color_type color_high,
   input bc1_pkg::color_type color_low
);

   `BC1_ASSERT_IMPLY(busy_while_rsp, clock, reset, rsp_valid, !req_ready)
   `BC1_ASSERT_IMPLY(four_color_order, clock, reset, rsp_valid, color_high > color_low)
   `BC1_ASSERT_NEXT(ready_after_rsp, clock, reset, rsp_valid && rsp_ready, req_ready)
   `BC1_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(color_high) && $stable(color_low))

endmodule

bind bc1_block_encoder_unit bc1_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .color_high (rsp_ch.color_high),
   .color_low  (rsp_ch.color_low)
);

/* tb/bc1_block_code_checker.sv */
// Checker that predicts the BC1 code of every pixel block and compares the encoder's responses.
`timescale 1ns / 100ps
module bc1_block_code_checker (
   input  logic clock,
   input  logic reset,
   bc1_req_if   req_ch,
   bc1_rsp_if   rsp_ch,
   output int   mismatches,
   output int   expected_left
);

   localparam int unsigned ScoreStart = 1000000;

   typedef struct packed {
      bc1_pkg::color_type color_high;
      bc1_pkg::color_type color_low;
      logic [31:0]        index_bits;
   } block_code_type;

   bc1_pkg::pixel_type block_px [bc1_pkg::BlockPixels];
   bc1_pkg::addr_type  fill_level;
   block_code_type     pending_codes [$];

   function automatic bc1_pkg::dist_type color_dist(input bc1_pkg::pixel_type p,
                                                    input bc1_pkg::pixel_type q);
      int dr, dg, db;
      dr = int'(p[23:16]) - int'(q[23:16]);
      dg = int'(p[15:8]) - int'(q[15:8]);
      db = int'(p[7:0]) - int'(q[7:0]);
      return bc1_pkg::dist_type'(dr * dr + dg * dg + db * db);
   endfunction

   function automatic bc1_pkg::addr_type farthest_pixel(
         input bc1_pkg::pixel_type px [bc1_pkg::BlockPixels],
         input bc1_pkg::addr_type from);
      bc1_pkg::addr_type best;
      int                best_d;
      int                d;
      best   = from;
      best_d = -1;
      for (int i = 0; i < bc1_pkg::BlockPixels; i++) begin
         d = int'(color_dist(px[i], px[from]));
         if (d > best_d) begin
            best_d = d;
            best   = bc1_pkg::addr_type'(i);
         end
      end
      return best;
   endfunction

   function automatic bc1_pkg::color_type to_565(input bc1_pkg::pixel_type p);
      return bc1_pkg::color_type'({p[23:19], p[15:10], p[7:3]});
   endfunction

   function automatic bc1_pkg::pixel_type widen_565(input bc1_pkg::color_type v);
      int unsigned r5, g6, b5;
      r5 = v[15:11];
      g6 = v[10:5];
      b5 = v[4:0];
      return {8'((r5 * 255 + 15) / 31), 8'((g6 * 255 + 31) / 63), 8'((b5 * 255 + 15) / 31)};
   endfunction

   function automatic block_code_type encode_block(
         input bc1_pkg::pixel_type px [bc1_pkg::BlockPixels]);
      bc1_pkg::addr_type  far_a, far_b;
      bc1_pkg::color_type c0, c1, swap;
      bc1_pkg::pixel_type pal [4];
      int unsigned        ch0, ch1, d, score;
      logic [1:0]         pick;
      block_code_type     code;
      far_a = farthest_pixel(px, '0);
      far_b = farthest_pixel(px, far_a);
      c0 = to_565(px[far_a]);
      c1 = to_565(px[far_b]);
      // nudge equal endpoints apart, then order them
      if (c0 == c1) begin
         if (c0 != bc1_pkg::Max565) c0 = c0 + 1'b1;
         else c1 = c1 - 1'b1;
      end
      if (c0 < c1) begin
         swap = c0;
         c0   = c1;
         c1   = swap;
      end
      pal[0] = widen_565(c0);
      pal[1] = widen_565(c1);
      for (int c = 0; c < 3; c++) begin
         ch0 = pal[0][8*c +: 8];
         ch1 = pal[1][8*c +: 8];
         pal[2][8*c +: 8] = 8'((2 * ch0 + ch1) / 3);
         pal[3][8*c +: 8] = 8'((ch0 + 2 * ch1) / 3);
      end
      code.color_high = c0;
      code.color_low  = c1;
      code.index_bits = '0;
      for (int i = 0; i < bc1_pkg::BlockPixels; i++) begin
         pick  = '0;
         score = ScoreStart;
         for (int k = 0; k < 4; k++) begin
            d = color_dist(px[i], pal[k]);
            if (d < score) begin
               score = d;
               pick  = 2'(k);
            end
         end
         code.index_bits[2*i +: 2] = pick;
      end
      return code;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      block_code_type want;
      if (reset) begin
         fill_level = '0;
         mismatches = 0;
         pending_codes.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            block_px[fill_level] = {req_ch.red, req_ch.green, req_ch.blue};
            if (fill_level == bc1_pkg::LastPixel)
               pending_codes = {pending_codes, encode_block(block_px)};
            fill_level = fill_level + 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_codes.size() == 0) begin
               mismatches++;
               $display("%0t: response with no block pending, expected none got %h %h %h",
                        $time, rsp_ch.color_high, rsp_ch.color_low, rsp_ch.index_bits);
            end else begin
               want = pending_codes.pop_front();
               check_field("color_high", 32'(want.color_high), 32'(rsp_ch.color_high));
               check_field("color_low", 32'(want.color_low), 32'(rsp_ch.color_low));
               check_field("index_bits", want.index_bits, rsp_ch.index_bits);
            end
         end
      end
      expected_left <= pending_codes.size();
   end

endmodule

/* tb/bc1_block_encoder_unit_test.sv */
// Top of the BC1 encoder test: clock, reset, pixel stimulus, response flow control and verdict.
`timescale 1ns / 100ps
module bc1_block_encoder_unit_test;

   localparam int RandomBlocks  = 114;
   localparam int PressureBlock = 86;
   localparam int HoldOffCycles = 400;
   localparam int DrainCycles   = 150;
   localparam int CycleLimit    = 400000;

   typedef enum int {
      KIND_WHITE,
      KIND_CORNERS,
      KIND_FLAT,
      KIND_BUCKET,
      KIND_TWO_TONE,
      KIND_RAMP,
      KIND_TIES,
      KIND_NOISE
   } block_kind_type;

   localparam bc1_pkg::pixel_type CornerBlock [bc1_pkg::BlockPixels] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
      24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00,
      24'h000000, 24'h808080, 24'h7F7F7F, 24'hFFFFFF,
      24'h010101, 24'hFEFEFE, 24'h000000, 24'hFF0000
   };

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   hold_off_req;
   int   cycle_count;
   int   mismatches;
   int   expected_left;

   bc1_req_if req_if();
   bc1_rsp_if rsp_if();

   bc1_block_encoder_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   bc1_block_code_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_if),
      .rsp_ch        (rsp_if),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // response flow control, with one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic int idle_share();
      case ($urandom_range(2))
         0: return 0;
         1: return 13;
         default: return 79;
      endcase
   endfunction

   task automatic send_block(input block_kind_type kind);
      bc1_pkg::pixel_type blk [bc1_pkg::BlockPixels];
      bc1_pkg::pixel_type c0, c1;
      int unsigned        lo, hi;
      c0 = bc1_pkg::pixel_type'($urandom);
      c1 = bc1_pkg::pixel_type'($urandom);
      case ($urandom_range(3))
         0: c0 = '0;
         1: c0 = '1;
         default: ;
      endcase
      for (int i = 0; i < bc1_pkg::BlockPixels; i++) begin
         case (kind)
            KIND_WHITE:    blk[i] = '1;
            KIND_CORNERS:  blk[i] = CornerBlock[i];
            KIND_FLAT:     blk[i] = c0;
            KIND_BUCKET:
               blk[i] = (c0 & 24'hF8FCF8) | (bc1_pkg::pixel_type'($urandom) & 24'h070307);
            KIND_TWO_TONE: blk[i] = $urandom_range(1) ? c0 : c1;
            KIND_RAMP: begin
               for (int ch = 0; ch < 3; ch++) begin
                  lo = c0[8*ch +: 8];
                  hi = c1[8*ch +: 8];
                  blk[i][8*ch +: 8] =
                     8'((lo * (bc1_pkg::BlockPixels - 1 - i) + hi * i) /
                        (bc1_pkg::BlockPixels - 1));
               end
            end
            KIND_TIES: begin
               case ($urandom_range(3))
                  0: blk[i] = '0;
                  1: blk[i] = '1;
                  2: blk[i] = c1;
                  default: blk[i] = ~c1;
               endcase
            end
            default: blk[i] = bc1_pkg::pixel_type'($urandom);
         endcase
      end
      for (int i = 0; i < bc1_pkg::BlockPixels; i++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
         end
         req_if.valid <= 1'b1;
         {req_if.red, req_if.green, req_if.blue} <= blk[i];
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         @(negedge clock);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.red     = '0;
      req_if.green   = '0;
      req_if.blue    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_req   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_block(KIND_WHITE);
      send_block(KIND_CORNERS);

      for (int b = 0; b < RandomBlocks; b++) begin
         if (b < 20) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else if (b < 42) begin
            send_idle_pct  = 79;
            recv_stall_pct = 0;
         end else if (b < 64) begin
            send_idle_pct  = 0;
            recv_stall_pct = 79;
         end else if (b < PressureBlock) begin
            send_idle_pct  = 13;
            recv_stall_pct = 13;
         end else if (b < PressureBlock + 6) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            if (b == PressureBlock) hold_off_req = 1'b1;
         end else begin
            send_idle_pct  = idle_share();
            recv_stall_pct = idle_share();
         end
         send_block(block_kind_type'($urandom_range(int'(KIND_NOISE), int'(KIND_FLAT))));
      end

      req_if.valid <= 1'b0;
      while (expected_left != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
